[hw/rtl/block_bitmap_allocator_core_defines.svh]
// Assertion macros for the block bitmap allocator.
`ifndef BLOCK_BITMAP_ALLOCATOR_CORE_DEFINES_SVH
`define BLOCK_BITMAP_ALLOCATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset
`define BBA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle
`define BBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BBA_ASSERT(lbl, clk, rst_n, prop, msg)
`define BBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[hw/rtl/bba_pkg.sv]
// Shared types and constants for the block bitmap allocator.
package bba_pkg;

  // Field widths
  localparam int CMD_W       = 2;
  localparam int IDX_W       = 10;
  localparam int CFG_W       = 11;
  localparam int STAT_W      = 2;
  localparam int FREE_W      = 11;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  // Block count after reset
  localparam int BC_RESET = 1024;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC     = 2'd0,
    CMD_MARK_USED = 2'd1,
    CMD_MARK_FREE = 2'd2,
    CMD_NOP       = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

endpackage

[hw/rtl/bba_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds its data while idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/bba_find.sv]
// First-free search over one bitmap word, limited to the managed blocks.
module bba_find #(
  parameter int WORD_BITS = 32,
  parameter int CNT_W     = 11
) (
  input  logic [WORD_BITS-1:0]         used_word,
  input  logic [CNT_W-1:0]             remain,
  output logic                         found,
  output logic [$clog2(WORD_BITS)-1:0] pos
);

  localparam int BIT_W = $clog2(WORD_BITS);
  localparam int RW    = (CNT_W > BIT_W + 1) ? CNT_W : BIT_W + 1;

  logic [WORD_BITS-1:0] avail;

  // Block j of the word sits at bit WORD_BITS-1-j and counts only below the limit
  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      avail[j] = !used_word[WORD_BITS-1-j] && (RW'(j) < RW'(remain));
    end
  end

  // Pick the lowest available block
  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (avail[j]) begin
        found = 1'b1;
        pos   = BIT_W'(j);
      end
    end
  end

endmodule

[hw/rtl/block_bitmap_allocator_core.sv]
// Top level of the block bitmap allocator: command sequencer around the bitmap RAM.
//
// Keeps one used/free bit per storage block in a RAM of WORD_BITS-wide words (block n is
// bit WORD_BITS-1-(n mod WORD_BITS) of word n/WORD_BITS) plus a running free count.
// A mark-used or mark-free command does one RAM read, then the modify and write-back.
// An allocate scans at most ceil(block_count/WORD_BITS) words (one when block_count is
// zero); the scan reads one word per cycle through the single RAM read port and stops
// at the first word holding a free block. One command is in flight at a time; a result
// that cannot leave because the output is stalled waits in a holding register until
// the output slot is free. Reset and every block_count write clear the map at once
// through per-word valid flags, so no clearing pass is needed.
// WORD_BITS must be a power of two.

`include "block_bitmap_allocator_core_defines.svh"

module block_bitmap_allocator_core #(
  parameter int MAX_BLOCKS = 1024,
  parameter int WORD_BITS  = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration: block_count
  input  logic                                cfg_wr_en,
  input  logic [bba_pkg::CFG_W-1:0]           cfg_wr_data,
  // Command stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [bba_pkg::IN_TDATA_W-1:0]      in_tdata,   // [9:0] block_index, rest zero
  input  logic [bba_pkg::CMD_W-1:0]           in_tuser,   // [1:0] command
  // Result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [bba_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [9:0] block_number,
                                                          // [20:10] free_count, rest zero
  output logic [bba_pkg::STAT_W-1:0]          out_tuser   // [1:0] status
);

  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int WORD_COUNT = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int WA_W       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int CMP_W      = (CNT_W > bba_pkg::CFG_W) ? CNT_W : bba_pkg::CFG_W;
  localparam int IX_W       = (CNT_W > bba_pkg::IDX_W) ? CNT_W : bba_pkg::IDX_W;
  localparam int RESET_CNT  = (bba_pkg::BC_RESET > MAX_BLOCKS) ? MAX_BLOCKS
                                                               : bba_pkg::BC_RESET;
  localparam int PAD_W      = bba_pkg::OUT_TDATA_W - bba_pkg::IDX_W - bba_pkg::FREE_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_WAIT
  } state_t;

  state_t                        state_r, state_nxt;
  bba_pkg::cmd_t                 cmd_r, cmd_nxt;
  logic [bba_pkg::IDX_W-1:0]     idx_r, idx_nxt;
  logic [WA_W-1:0]               word_addr_r, word_addr_nxt;
  logic [CNT_W-1:0]              bc_r, bc_nxt;
  logic [CNT_W-1:0]              free_r, free_nxt;
  logic [WORD_COUNT-1:0]         valid_r, valid_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [bba_pkg::IDX_W-1:0]     out_num_r, out_num_nxt;
  bba_pkg::status_t              out_status_r, out_status_nxt;
  logic [bba_pkg::FREE_W-1:0]    out_free_r, out_free_nxt;
  logic [bba_pkg::IDX_W-1:0]     pend_num_r, pend_num_nxt;
  bba_pkg::status_t              pend_status_r, pend_status_nxt;
  logic [bba_pkg::FREE_W-1:0]    pend_free_r, pend_free_nxt;

  // RAM ports
  logic                          ram_we, ram_re;
  logic [WA_W-1:0]               ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0]          ram_wdata, ram_rdata;

  // Datapath
  logic [WORD_BITS-1:0]          word_eff;
  logic [CNT_W-1:0]              remain;
  logic [CNT_W-1:0]              bc_m1;
  logic [WA_W-1:0]               last_w;
  logic                          fnd;
  logic [BIT_W-1:0]              fnd_pos;
  logic [bba_pkg::IDX_W-1:0]     in_idx;
  logic [WA_W-1:0]               in_word;
  logic                          slot_free;
  logic                          fin;
  logic [bba_pkg::IDX_W-1:0]     res_num;
  bba_pkg::status_t              res_status;
  logic                          in_range;
  logic                          want_used;
  logic [BIT_W-1:0]              mark_sel;
  logic [CNT_W-1:0]              cfg_sat;

  bba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORD_COUNT)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Words never written since the last clear read as all free
  assign word_eff = valid_r[word_addr_r] ? ram_rdata : '0;

  // Blocks left to consider from the start of the current word, and the last word
  assign remain = bc_r - CNT_W'({word_addr_r, {BIT_W{1'b0}}});
  assign bc_m1  = bc_r - CNT_W'(1);
  assign last_w = (bc_r == '0) ? '0 : WA_W'(bc_m1 >> BIT_W);

  bba_find #(
    .WORD_BITS (WORD_BITS),
    .CNT_W     (CNT_W)
  ) u_find (
    .used_word (word_eff),
    .remain    (remain),
    .found     (fnd),
    .pos       (fnd_pos)
  );

  assign in_idx    = in_tdata[bba_pkg::IDX_W-1:0];
  assign in_word   = WA_W'(IX_W'(in_idx) >> BIT_W);
  assign in_range  = IX_W'(idx_r) < IX_W'(bc_r);
  assign want_used = (cmd_r == bba_pkg::CMD_MARK_USED);
  assign mark_sel  = ~idx_r[BIT_W-1:0];
  assign slot_free = !out_valid_r || out_tready;
  assign cfg_sat   = (CMP_W'(cfg_wr_data) > CMP_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                                : CNT_W'(cfg_wr_data);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_free_r, out_num_r};
  assign out_tuser  = out_status_r;

  // Sequencer: issue reads, modify and write back, route the result
  always_comb begin
    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    idx_nxt         = idx_r;
    word_addr_nxt   = word_addr_r;
    bc_nxt          = bc_r;
    free_nxt        = free_r;
    valid_nxt       = valid_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_num_nxt     = out_num_r;
    out_status_nxt  = out_status_r;
    out_free_nxt    = out_free_r;
    pend_num_nxt    = pend_num_r;
    pend_status_nxt = pend_status_r;
    pend_free_nxt   = pend_free_r;
    ram_we          = 1'b0;
    ram_waddr       = word_addr_r;
    ram_wdata       = word_eff;
    ram_re          = 1'b0;
    ram_raddr       = '0;
    fin             = 1'b0;
    res_num         = '0;
    res_status      = bba_pkg::ST_OK;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt = bba_pkg::cmd_t'(in_tuser);
          idx_nxt = in_idx;
          ram_re  = 1'b1;
          if (bba_pkg::cmd_t'(in_tuser) == bba_pkg::CMD_ALLOC) begin
            ram_raddr     = '0;
            word_addr_nxt = '0;
            state_nxt     = S_SCAN;
          end else begin
            ram_raddr     = in_word;
            word_addr_nxt = in_word;
            state_nxt     = S_MARK;
          end
        end
      end

      S_SCAN: begin
        if (fnd) begin
          // Claim the first free block of this word
          ram_we                 = 1'b1;
          ram_wdata[~fnd_pos]    = 1'b1;
          valid_nxt[word_addr_r] = 1'b1;
          free_nxt               = free_r - CNT_W'(1);
          fin                    = 1'b1;
          res_num                = bba_pkg::IDX_W'({word_addr_r, fnd_pos});
        end else if (word_addr_r == last_w) begin
          fin        = 1'b1;
          res_status = bba_pkg::ST_NO_FREE;
        end else begin
          // Fetch the next word while this one is checked
          ram_re        = 1'b1;
          ram_raddr     = word_addr_r + WA_W'(1);
          word_addr_nxt = word_addr_r + WA_W'(1);
        end
      end

      S_MARK: begin
        fin = 1'b1;
        case (cmd_r)
          bba_pkg::CMD_MARK_USED, bba_pkg::CMD_MARK_FREE: begin
            res_num = idx_r;
            if (!in_range) begin
              res_status = bba_pkg::ST_RANGE;
            end else if (word_eff[mark_sel] != want_used) begin
              // Flip the bit and track the free count
              ram_we                 = 1'b1;
              ram_wdata[mark_sel]    = want_used;
              valid_nxt[word_addr_r] = 1'b1;
              free_nxt               = want_used ? free_r - CNT_W'(1)
                                                 : free_r + CNT_W'(1);
            end
          end
          default: begin
            res_num = '0;
          end
        endcase
      end

      S_WAIT: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_num_nxt    = pend_num_r;
          out_status_nxt = pend_status_r;
          out_free_nxt   = pend_free_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Deliver the result, or hold it while the output is stalled
    if (fin) begin
      if (slot_free) begin
        out_valid_nxt  = 1'b1;
        out_num_nxt    = res_num;
        out_status_nxt = res_status;
        out_free_nxt   = bba_pkg::FREE_W'(free_nxt);
        state_nxt      = S_IDLE;
      end else begin
        pend_num_nxt    = res_num;
        pend_status_nxt = res_status;
        pend_free_nxt   = bba_pkg::FREE_W'(free_nxt);
        state_nxt       = S_WAIT;
      end
    end

    // Load a new block count and clear the map
    if (cfg_wr_en) begin
      bc_nxt    = cfg_sat;
      free_nxt  = cfg_sat;
      valid_nxt = '0;
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bc_r        <= CNT_W'(RESET_CNT);
      free_r      <= CNT_W'(RESET_CNT);
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bc_r        <= bc_nxt;
      free_r      <= free_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r         <= cmd_nxt;
    idx_r         <= idx_nxt;
    word_addr_r   <= word_addr_nxt;
    out_num_r     <= out_num_nxt;
    out_status_r  <= out_status_nxt;
    out_free_r    <= out_free_nxt;
    pend_num_r    <= pend_num_nxt;
    pend_status_r <= pend_status_nxt;
    pend_free_r   <= pend_free_nxt;
  end

  // The free count never exceeds the managed blocks
  `BBA_ASSERT(a_free_le_count, clk, rst_n, free_r <= bc_r, "free count above block count")
  // A transfer starts a command that blocks further transfers in the next cycle
  `BBA_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_tvalid && in_tready, !in_tready, "second command taken while busy")
  // Write-back stays inside the managed part of the map
  `BBA_ASSERT(a_write_in_map, clk, rst_n, ram_we |-> (word_addr_r <= last_w), "bitmap write beyond block count")

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the first-fit block bitmap allocator core.
`timescale 1ns / 100ps

module tb;
  import bba_pkg::*;

  localparam int MAP_BLOCKS = BC_RESET;
  localparam int LONG_HOLD  = 300;

  typedef struct packed {
    logic [IDX_W-1:0]  number;
    status_t           status;
    logic [FREE_W-1:0] free_count;
  } alloc_result_t;

  // Usage map, free count and block count kept in step with the core
  class alloc_scoreboard;
    bit [MAP_BLOCKS-1:0] used_map;
    int unsigned         blocks;
    int unsigned         free_left;
    alloc_result_t       expected_q[$];
    int unsigned         errors;

    function void load_count(input logic [CFG_W-1:0] value);
      int unsigned v;
      v = value;
      if (v > MAP_BLOCKS) v = MAP_BLOCKS;
      blocks    = v;
      free_left = v;
      used_map  = '0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Apply one accepted command and queue the result it should produce
    function void note_command(input cmd_t cmd, input logic [IDX_W-1:0] idx);
      alloc_result_t res;
      int unsigned   n;
      bit            want_used;
      res.number = '0;
      res.status = ST_OK;
      case (cmd)
        CMD_ALLOC: begin
          n = 0;
          while (n < blocks && used_map[n]) n++;
          if (n < blocks) begin
            used_map[n] = 1'b1;
            free_left--;
            res.number = IDX_W'(n);
          end else begin
            res.status = ST_NO_FREE;
          end
        end
        CMD_MARK_USED, CMD_MARK_FREE: begin
          res.number = idx;
          want_used  = (cmd == CMD_MARK_USED);
          if (idx >= blocks) begin
            res.status = ST_RANGE;
          end else if (used_map[idx] != want_used) begin
            used_map[idx] = want_used;
            if (want_used) free_left--;
            else free_left++;
          end
        end
        default: begin
          // ignored command: plain ok, nothing moves
        end
      endcase
      res.free_count = FREE_W'(free_left);
      expected_q.push_back(res);
    endfunction

    // Compare one result transfer against the oldest expectation
    function void check_result(input logic [IDX_W-1:0] number, input status_t status,
                               input logic [FREE_W-1:0] free_count);
      alloc_result_t exp_res;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result number=%0d status=%0d free=%0d",
                 $time, number, status, free_count);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (number !== exp_res.number) begin
        $display("%0t: block_number expected %0d actual %0d",
                 $time, exp_res.number, number);
        errors++;
      end
      if (status !== exp_res.status) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_res.status, status);
        errors++;
      end
      if (free_count !== exp_res.free_count) begin
        $display("%0t: free_count expected %0d actual %0d",
                 $time, exp_res.free_count, free_count);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]       cfg_wr_data = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [9:0] block_index
  logic [CMD_W-1:0]       in_tuser = '0;   // [1:0] command
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [9:0] block_number, [20:10] free_count
  logic [STAT_W-1:0]      out_tuser;       // [1:0] status

  alloc_scoreboard sb;
  bit              burst_mode = 1'b0;
  bit              hold_off_req = 1'b0;

  block_bitmap_allocator_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard stop for a hung run
  initial begin
    #6ms;
    $display("*** FAILED ***");
    $finish;
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata[IDX_W-1:0], status_t'(out_tuser),
                      out_tdata[IDX_W+FREE_W-1:IDX_W]);
    end
  end

  // Receiver: random ready runs and stalls, one long hold-off on request
  initial begin : receiver
    int r;
    int len;
    wait (rst_n);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          out_tready <= 1'b1;
          len = $urandom_range(1, 30);
        end else if (r < 90) begin
          out_tready <= 1'b0;
          len = $urandom_range(1, 3);
        end else begin
          out_tready <= 1'b0;
          len = $urandom_range(10, 60);
        end
        repeat (len) @(posedge clk);
      end
    end
  end

  // Sender gap: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(15, 50);
  endfunction

  // Offer one command, hold it until the transfer, then idle a while
  task automatic send_command(input cmd_t cmd, input logic [IDX_W-1:0] idx);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= IN_TDATA_W'(idx);
    do @(posedge clk); while (!in_tready);
    sb.note_command(cmd, idx);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait for every outstanding result
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Write block_count while the core is idle
  task automatic set_block_count(input logic [CFG_W-1:0] value);
    wait_idle();
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.load_count(value);
  endtask

  // Random commands under one block count, percentages per command kind
  task automatic run_phase(input logic [CFG_W-1:0] count_value, input int n_items,
                           input int alloc_pct, input int used_pct, input int free_pct,
                           input bit pressure);
    int               r;
    int               ri;
    cmd_t             cmd;
    logic [IDX_W-1:0] idx;
    set_block_count(count_value);
    burst_mode = pressure || ($urandom_range(0, 3) == 0);
    if (pressure) hold_off_req = 1'b1;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (r < alloc_pct) cmd = CMD_ALLOC;
      else if (r < alloc_pct + used_pct) cmd = CMD_MARK_USED;
      else if (r < alloc_pct + used_pct + free_pct) cmd = CMD_MARK_FREE;
      else cmd = CMD_NOP;
      ri = $urandom_range(0, 99);
      if (ri < 80 && sb.blocks > 0) idx = IDX_W'($urandom_range(0, sb.blocks - 1));
      else if (ri < 95) idx = IDX_W'($urandom_range(0, MAP_BLOCKS - 1));
      else if (ri < 97) idx = '0;
      else idx = '1;
      send_command(cmd, idx);
    end
    burst_mode = 1'b0;
  endtask

  // Main sequence
  initial begin : stimulus
    sb = new;
    sb.load_count(CFG_W'(BC_RESET));
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset count: first fit, repeated marks, ignored command, index bit patterns
    send_command(CMD_ALLOC, '0);
    send_command(CMD_ALLOC, '1);
    send_command(CMD_MARK_USED, 10'd1023);
    send_command(CMD_MARK_USED, 10'd1023);
    send_command(CMD_MARK_FREE, 10'd0);
    send_command(CMD_MARK_FREE, 10'd0);
    send_command(CMD_ALLOC, 10'd0);
    send_command(CMD_NOP, 10'd1023);
    send_command(CMD_MARK_USED, 10'h2AA);
    send_command(CMD_MARK_USED, 10'h155);
    send_command(CMD_MARK_FREE, 10'd1023);

    // No blocks managed
    set_block_count(CFG_W'(0));
    send_command(CMD_ALLOC, '0);
    send_command(CMD_MARK_USED, 10'd0);
    send_command(CMD_MARK_FREE, 10'd1023);
    send_command(CMD_NOP, 10'd0);

    // One block: fill, run dry, out of range, release
    set_block_count(CFG_W'(1));
    send_command(CMD_ALLOC, '0);
    send_command(CMD_ALLOC, '0);
    send_command(CMD_MARK_USED, 10'd1);
    send_command(CMD_MARK_FREE, 10'd0);
    send_command(CMD_ALLOC, '0);
    send_command(CMD_MARK_FREE, 10'd1023);

    // Oversized count saturates to the full map
    set_block_count('1);
    send_command(CMD_MARK_USED, 10'd1023);
    send_command(CMD_ALLOC, '0);

    // Fill the full map until allocation runs dry
    run_phase(CFG_W'(BC_RESET), 1150, 95, 3, 2, 1'b0);
    // Small map with a long output stall
    run_phase(CFG_W'(7), 80, 40, 25, 30, 1'b1);
    run_phase(CFG_W'(33), 90, 45, 20, 30, 1'b0);
    run_phase(CFG_W'(1), 40, 40, 25, 30, 1'b0);
    run_phase(CFG_W'(BC_RESET), 100, 40, 25, 30, 1'b0);
    run_phase(CFG_W'($urandom_range(2, MAP_BLOCKS - 1)), 100, 40, 25, 30, 1'b0);
    run_phase(CFG_W'(64), 100, 50, 20, 25, 1'b0);
    run_phase(CFG_W'(0), 20, 40, 25, 30, 1'b0);

    // Drain, then watch for stray results
    wait_idle();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
